FILE: rtl/touch_region_hit_table_macros.svh
// Assertion helpers used by the touch table RTL.
`ifndef TOUCH_REGION_HIT_TABLE_MACROS_SVH
`define TOUCH_REGION_HIT_TABLE_MACROS_SVH

// Same-cycle implication.
`define THT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("touch table check failed");

// Next-cycle implication.
`define THT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("touch table check failed");

`endif

FILE: rtl/thtab_pkg.sv
`timescale 1ns / 1ps
package thtab_pkg;

  localparam int unsigned COORD_W = 12;
  localparam int unsigned SLOT_W  = 4;
  localparam int unsigned CMD_W   = 3;
  localparam int unsigned STAT_W  = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD     = 3'd0,
    CMD_DELETE  = 3'd1,
    CMD_ENABLE  = 3'd2,
    CMD_DISABLE = 3'd3,
    CMD_CLEAR   = 3'd4,
    CMD_TOUCH   = 3'd5
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_DONE = 2'd0,
    STAT_FULL = 2'd1,
    STAT_MISS = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_ADD,
    ST_TOUCH,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic [COORD_W-1:0] rect_width;
    logic [COORD_W-1:0] rect_height;
    logic               start_disabled;
    logic [SLOT_W-1:0]  slot;
  } req_t;

  typedef struct packed {
    status_e           status;
    logic [SLOT_W-1:0] hit_slot;
    logic              slot_enabled;
  } rsp_t;

  // One stored rectangle.
  typedef struct packed {
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] top;
    logic [COORD_W-1:0] span_x;
    logic [COORD_W-1:0] span_y;
  } rect_t;

endpackage

FILE: rtl/thtab_if.sv
`timescale 1ns / 1ps
interface thtab_req_if;
  import thtab_pkg::*;
  logic valid;
  logic ready;
  req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface thtab_rsp_if;
  import thtab_pkg::*;
  logic valid;
  logic ready;
  rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/thtab_ram.sv
`timescale 1ns / 1ps
module thtab_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: rtl/touch_region_hit_table.sv
// Add scans the slots from slot 0 and writes the first free slot it finds.
// Touch does one RAM read and one compare per slot, up to a hit or the last slot.
// Delete, enable, disable, clear and unknown commands go through ST_EXEC to ST_RESP.
// One request at a time; the next is taken the cycle after the result is taken.
// Reset (async, active low) empties the table; rectangle RAM needs no clearing.
`timescale 1ns / 1ps
module touch_region_hit_table #(
  parameter int unsigned NUM_SLOTS = 16
) (
  input logic         clk_i,
  input logic         rst_ni,
  thtab_req_if.sink   req_i,
  thtab_rsp_if.source rsp_o
);
  import thtab_pkg::*;

  localparam int unsigned IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned CNT_W = $clog2(NUM_SLOTS + 1);
  localparam int unsigned CMP_W = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;
  localparam int unsigned REC_W = $bits(rect_t);

  state_e                 state_q, state_d;
  req_t                   req_q;
  rsp_t                   res_q, res_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic                   chk_vld_q, chk_vld_d;
  logic [IDX_W-1:0]       chk_idx_q, chk_idx_d;
  logic [NUM_SLOTS-1:0]   in_use_q, in_use_d;
  logic [NUM_SLOTS-1:0]   dis_q, dis_d;

  logic                   req_fire;
  logic [IDX_W-1:0]       sidx;
  logic                   scan_last;
  logic                   chk_last;
  logic                   ram_we;
  rect_t                  wr_rect;
  logic [REC_W-1:0]       rd_word;
  rect_t                  rd_rect;
  logic                   inside_x;
  logic                   inside_y;
  logic                   hit;
  logic [CMP_W-1:0]       slot_w;
  logic                   slot_ok;
  logic [IDX_W-1:0]       slot_idx;
  logic [CMP_W-1:0]       sidx_w;
  logic [CMP_W-1:0]       chk_w;
  logic                   new_dis;

  assign req_fire  = req_i.valid && req_i.ready;
  assign sidx      = cnt_q[IDX_W-1:0];
  assign scan_last = (cnt_q == CNT_W'(NUM_SLOTS - 1));
  assign chk_last  = (chk_idx_q == IDX_W'(NUM_SLOTS - 1));

  assign slot_w   = CMP_W'(req_q.slot);
  assign slot_ok  = (slot_w < CMP_W'(NUM_SLOTS));
  assign slot_idx = slot_w[IDX_W-1:0];
  assign sidx_w   = CMP_W'(sidx);
  assign chk_w    = CMP_W'(chk_idx_q);

  assign wr_rect = '{left: req_q.pos_x, top: req_q.pos_y,
                     span_x: req_q.rect_width, span_y: req_q.rect_height};

  thtab_ram #(
    .WIDTH (REC_W),
    .DEPTH (NUM_SLOTS)
  ) u_rect_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (sidx),
    .wdata_i (wr_rect),
    .raddr_i (sidx),
    .rdata_o (rd_word)
  );

  assign rd_rect = rect_t'(rd_word);

  // Shared containment check, inclusive edges, one extra bit so the sum cannot wrap.
  assign inside_x = (req_q.pos_x >= rd_rect.left) &&
                    ({1'b0, req_q.pos_x} <= ({1'b0, rd_rect.left} + {1'b0, rd_rect.span_x}));
  assign inside_y = (req_q.pos_y >= rd_rect.top) &&
                    ({1'b0, req_q.pos_y} <= ({1'b0, rd_rect.top} + {1'b0, rd_rect.span_y}));
  assign hit = in_use_q[chk_idx_q] && !dis_q[chk_idx_q] && inside_x && inside_y;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          if (req_i.payload.command == CMD_ADD) begin
            state_d = ST_ADD;
          end else if (req_i.payload.command == CMD_TOUCH) begin
            state_d = ST_TOUCH;
          end else begin
            state_d = ST_EXEC;
          end
        end
      end
      ST_EXEC: state_d = ST_RESP;
      ST_ADD: begin
        if (!in_use_q[sidx] || scan_last) begin
          state_d = ST_RESP;
        end
      end
      ST_TOUCH: begin
        if (chk_vld_q && (hit || chk_last)) begin
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (rsp_o.ready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and table updates
  always_comb begin
    cnt_d     = cnt_q;
    chk_vld_d = 1'b0;
    chk_idx_d = chk_idx_q;
    in_use_d  = in_use_q;
    dis_d     = dis_q;
    res_d     = res_q;
    ram_we    = 1'b0;
    new_dis   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
      end
      ST_EXEC: begin
        res_d = '{status: STAT_DONE, hit_slot: '0, slot_enabled: 1'b0};
        unique case (req_q.command)
          CMD_DELETE, CMD_ENABLE, CMD_DISABLE: begin
            if (slot_ok) begin
              new_dis = dis_q[slot_idx];
              if (in_use_q[slot_idx]) begin
                if (req_q.command == CMD_DELETE) begin
                  in_use_d[slot_idx] = 1'b0;
                  new_dis            = 1'b0;
                end else begin
                  new_dis = (req_q.command == CMD_DISABLE);
                end
                dis_d[slot_idx] = new_dis;
              end
              res_d.slot_enabled = !new_dis;
            end
          end
          CMD_CLEAR: begin
            in_use_d = '0;
            dis_d    = '0;
          end
          default: ;
        endcase
      end
      ST_ADD: begin
        cnt_d = cnt_q + 1'b1;
        if (!in_use_q[sidx]) begin
          ram_we          = 1'b1;
          in_use_d[sidx]  = 1'b1;
          dis_d[sidx]     = req_q.start_disabled;
          res_d = '{status: STAT_DONE, hit_slot: sidx_w[SLOT_W-1:0],
                    slot_enabled: !req_q.start_disabled};
        end else if (scan_last) begin
          res_d = '{status: STAT_FULL, hit_slot: '0, slot_enabled: 1'b0};
        end
      end
      ST_TOUCH: begin
        // read issued for sidx, checked in the next cycle as chk_idx_q
        if (cnt_q < CNT_W'(NUM_SLOTS)) begin
          chk_vld_d = 1'b1;
          chk_idx_d = sidx;
          cnt_d     = cnt_q + 1'b1;
        end
        if (chk_vld_q) begin
          if (hit) begin
            res_d = '{status: STAT_DONE, hit_slot: chk_w[SLOT_W-1:0], slot_enabled: 1'b1};
          end else if (chk_last) begin
            res_d = '{status: STAT_MISS, hit_slot: '0, slot_enabled: 1'b0};
          end
        end
      end
      ST_RESP: ;
      default: ;
    endcase
  end

  assign req_i.ready   = (state_q == ST_IDLE);
  assign rsp_o.valid   = (state_q == ST_RESP);
  assign rsp_o.payload = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      chk_vld_q <= 1'b0;
      chk_idx_q <= '0;
      in_use_q  <= '0;
      dis_q     <= '0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      chk_vld_q <= chk_vld_d;
      chk_idx_q <= chk_idx_d;
      in_use_q  <= in_use_d;
      dis_q     <= dis_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      req_q <= req_i.payload;
    end
    res_q <= res_d;
  end

`include "touch_region_hit_table_macros.svh"

  `THT_ASSERT_NOW(a_no_req_while_rsp, clk_i, rst_ni, rsp_o.valid, !req_i.ready)
  `THT_ASSERT_NEXT(a_accept_no_rsp, clk_i, rst_ni, req_fire, !rsp_o.valid)
  `THT_ASSERT_NOW(a_full_means_full, clk_i, rst_ni,
    rsp_o.valid && (rsp_o.payload.status == STAT_FULL), &in_use_q)
  `THT_ASSERT_NOW(a_miss_zero, clk_i, rst_ni,
    rsp_o.valid && (rsp_o.payload.status == STAT_MISS),
    (rsp_o.payload.hit_slot == '0) && !rsp_o.payload.slot_enabled)
  `THT_ASSERT_NEXT(a_clear_empties, clk_i, rst_ni,
    (state_q == ST_EXEC) && (req_q.command == CMD_CLEAR),
    (in_use_q == '0) && (dis_q == '0))
  `THT_ASSERT_NEXT(a_add_claims_slot, clk_i, rst_ni,
    (state_q == ST_ADD) && !in_use_q[sidx], in_use_q[$past(sidx)])

endmodule
